>>> hw/rtl/tssc_pkg.sv
// Shared constants, types and helpers for the text stream statistics counter.
`default_nettype none

package tssc_pkg;

    // Width of every result field on the output channel
    localparam int OUT_WIDTH = 48;
    // Default width of the internal running counters
    localparam int COUNT_WIDTH_DEF = 48;

    // UTF-8 continuation byte detection: top two bits equal to 10
    localparam logic [7:0] UTF8_TOP_MASK = 8'hC0;
    localparam logic [7:0] UTF8_CONT_CODE = 8'h80;

    // ASCII control and whitespace bytes
    localparam logic [7:0] ASCII_LF = 8'h0A;
    localparam logic [7:0] ASCII_CR = 8'h0D;
    localparam logic [7:0] ASCII_TAB = 8'h09;
    localparam logic [7:0] ASCII_VT = 8'h0B;
    localparam logic [7:0] ASCII_FF = 8'h0C;
    localparam logic [7:0] ASCII_SP = 8'h20;

    // One input item as held in the input register
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       stream_end;
    } t_in_item;

    // True for the six ASCII whitespace bytes that separate words
    function automatic logic f_is_blank(input logic [7:0] b);
        return b inside {ASCII_SP, ASCII_TAB, ASCII_LF, ASCII_CR, ASCII_VT, ASCII_FF};
    endfunction

    // True for ASCII bytes and UTF-8 lead bytes
    function automatic logic f_is_lead(input logic [7:0] b);
        return (b & UTF8_TOP_MASK) != UTF8_CONT_CODE;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tssc_if.sv
// Valid/ready channel interfaces for the byte input and the statistics output.
`default_nettype none

// Byte channel: one stream byte, its valid flag and the end-of-stream mark
interface tssc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       stream_end;

    modport source(output valid, data_byte, byte_valid, stream_end, input ready);
    modport sink(input valid, data_byte, byte_valid, stream_end, output ready);
endinterface

// Statistics channel: the five totals of one finished stream
interface tssc_stats_if
    import tssc_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [OUT_WIDTH-1:0] line_total;
    logic [OUT_WIDTH-1:0] word_total;
    logic [OUT_WIDTH-1:0] byte_total;
    logic [OUT_WIDTH-1:0] char_total;
    logic [OUT_WIDTH-1:0] longest_line;

    modport source(output valid, line_total, word_total, byte_total, char_total,
                   longest_line, input ready);
    modport sink(input valid, line_total, word_total, byte_total, char_total,
                 longest_line, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/text_stream_statistics_counter_core.sv
// Top level of the text stream statistics counter (UTF-8 aware).
//
// Takes one text byte per transfer on i_in and keeps saturating totals of
// bytes, UTF-8 characters, newlines, words and the longest line (in
// characters, CR and LF excluded). A transfer with stream_end set (with or
// without a byte) closes the open line, sends the five totals as one transfer
// on o_out and clears all counters. Throughput is one byte per clock; a byte
// goes from the input register through the update logic into the counters,
// and an end item goes from the input register into the result register.
// The input stalls only while an end item waits behind a result that the
// sink has not yet taken; ordinary bytes keep flowing during an output stall.
// Counters are COUNT_WIDTH bits wide; each result field carries them cut or
// zero-extended to 48 bits. No initialization pass is needed after reset.
`default_nettype none

module text_stream_statistics_counter_core
    import tssc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    tssc_byte_if.sink      i_in,
    tssc_stats_if.source   o_out
);

    localparam int CW = COUNT_WIDTH;

    // Saturating increment shared by all counters
    function automatic logic [CW-1:0] f_sat_inc(input logic [CW-1:0] x);
        return (&x) ? x : x + 1'b1;
    endfunction

    // Input register
    logic     r_item_valid;
    t_in_item r_item;

    // Running state
    logic          r_inside_word;
    logic [CW-1:0] r_open_len;
    logic [CW-1:0] r_lines;
    logic [CW-1:0] r_words;
    logic [CW-1:0] r_bytes;
    logic [CW-1:0] r_chars;
    logic [CW-1:0] r_longest;

    // Result register
    logic                 r_out_valid;
    logic [OUT_WIDTH-1:0] r_out_lines;
    logic [OUT_WIDTH-1:0] r_out_words;
    logic [OUT_WIDTH-1:0] r_out_bytes;
    logic [OUT_WIDTH-1:0] r_out_chars;
    logic [OUT_WIDTH-1:0] r_out_longest;

    // Next values
    logic          n_inside_word;
    logic [CW-1:0] n_open_len;
    logic [CW-1:0] n_lines;
    logic [CW-1:0] n_words;
    logic [CW-1:0] n_bytes;
    logic [CW-1:0] n_chars;
    logic [CW-1:0] n_longest;
    logic [CW-1:0] n_final_longest;

    logic in_fire;
    logic out_free;
    logic proc_fire;

    // Handshake: an end item needs a free result register, other items never wait
    assign out_free  = !r_out_valid || o_out.ready;
    assign proc_fire = r_item_valid && (!r_item.stream_end || out_free);
    assign i_in.ready = !r_item_valid || proc_fire;
    assign in_fire   = i_in.valid && i_in.ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (in_fire) begin
            r_item_valid <= 1'b1;
        end else if (proc_fire) begin
            r_item_valid <= 1'b0;
        end
        if (in_fire) begin
            r_item.data_byte  <= i_in.data_byte;
            r_item.byte_valid <= i_in.byte_valid;
            r_item.stream_end <= i_in.stream_end;
        end
    end

    // Per-byte update of all counters
    always_comb begin
        logic       take;
        logic       lead;
        logic       blank;
        logic       is_lf;
        logic       open_inc;
        logic       open_ge;
        logic       open_gt;
        logic [7:0] b;

        b        = r_item.data_byte;
        take     = r_item.byte_valid;
        lead     = f_is_lead(b);
        blank    = f_is_blank(b);
        is_lf    = take && (b == ASCII_LF);
        open_inc = take && !is_lf && (b != ASCII_CR) && lead;
        open_ge  = r_open_len >= r_longest;
        open_gt  = r_open_len > r_longest;

        n_bytes = take ? f_sat_inc(r_bytes) : r_bytes;
        n_chars = (take && lead) ? f_sat_inc(r_chars) : r_chars;

        // Words start on the first non-blank byte after a blank or the start
        n_inside_word = take ? !blank : r_inside_word;
        n_words = (take && !blank && !r_inside_word) ? f_sat_inc(r_words) : r_words;

        n_lines    = is_lf ? f_sat_inc(r_lines) : r_lines;
        n_longest  = (is_lf && open_gt) ? r_open_len : r_longest;
        n_open_len = is_lf ? '0 : (open_inc ? f_sat_inc(r_open_len) : r_open_len);

        // Longest line including the still open line, from pre-update compares
        if (is_lf) begin
            n_final_longest = n_longest;
        end else if (open_inc) begin
            n_final_longest = open_ge ? f_sat_inc(r_open_len) : r_longest;
        end else begin
            n_final_longest = open_gt ? r_open_len : r_longest;
        end
    end

    // State registers: cleared at the end of each stream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside_word <= 1'b0;
            r_open_len    <= '0;
            r_lines       <= '0;
            r_words       <= '0;
            r_bytes       <= '0;
            r_chars       <= '0;
            r_longest     <= '0;
        end else if (proc_fire) begin
            if (r_item.stream_end) begin
                r_inside_word <= 1'b0;
                r_open_len    <= '0;
                r_lines       <= '0;
                r_words       <= '0;
                r_bytes       <= '0;
                r_chars       <= '0;
                r_longest     <= '0;
            end else begin
                r_inside_word <= n_inside_word;
                r_open_len    <= n_open_len;
                r_lines       <= n_lines;
                r_words       <= n_words;
                r_bytes       <= n_bytes;
                r_chars       <= n_chars;
                r_longest     <= n_longest;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire && r_item.stream_end) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (proc_fire && r_item.stream_end) begin
            r_out_lines   <= OUT_WIDTH'(n_lines);
            r_out_words   <= OUT_WIDTH'(n_words);
            r_out_bytes   <= OUT_WIDTH'(n_bytes);
            r_out_chars   <= OUT_WIDTH'(n_chars);
            r_out_longest <= OUT_WIDTH'(n_final_longest);
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.line_total   = r_out_lines;
    assign o_out.word_total   = r_out_words;
    assign o_out.byte_total   = r_out_bytes;
    assign o_out.char_total   = r_out_chars;
    assign o_out.longest_line = r_out_longest;

    // A new result only follows a processed end item
    a_out_from_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(proc_fire && r_item.stream_end))
        else $error("result valid without a processed end item");

    // Counters start from zero after an end item
    a_clear_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_fire && r_item.stream_end) |=>
            (r_bytes == '0 && r_chars == '0 && r_lines == '0 && r_open_len == '0))
        else $error("counters not cleared after end of stream");

    // Characters are a subset of bytes; line lengths are bounded by characters
    a_count_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_chars <= r_bytes) && (r_open_len <= r_chars) && (r_longest <= r_chars))
        else $error("counter ordering violated");

    // The input only stalls behind an end item waiting for the result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_item_valid && r_item.stream_end && r_out_valid && !o_out.ready))
        else $error("input stalled without cause");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the text stream statistics counter core.
`default_nettype none

module tb_top;
    import tssc_pkg::*;

    localparam int CLK_PERIOD = 12;
    // Narrow counter width, so result fields are zero-extended counters
    localparam int CNT_W = 16;
    localparam int RANDOM_ITEMS = 1200;
    localparam int LONG_HOLD_CYCLES = 120;
    localparam longint LIMIT_CYCLES = 8_000_000;

    // Totals of one stream: [0] lines, [1] words, [2] bytes, [3] chars, [4] longest
    typedef logic [4:0][47:0] t_stats;

    typedef struct packed {
        logic [7:0] data;
        logic       bv;
        logic       se;
        logic       pin;
        t_stats     want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    tssc_byte_if  in_if ();
    tssc_stats_if out_if ();

    text_stream_statistics_counter_core #(
        .COUNT_WIDTH(CNT_W)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if.sink),
        .o_out  (out_if.source)
    );

    string field_name [5] = '{"line_total", "word_total", "byte_total", "char_total",
                              "longest_line"};

    t_stats   pending_totals [$];
    t_dir_row dir_rows [$];
    int       err_cnt = 0;
    int       items_sent = 0;
    int       rnd_base;
    bit       hold_done = 1'b0;
    bit       no_idle = 1'b0;
    bit       long_hold_req = 1'b0;

    // Expected value typed into the table, carried along with the transfer
    logic   pin_totals;
    t_stats pinned_totals;

    // Running state of the predictor
    logic [CNT_W-1:0] lines_cnt, words_cnt, bytes_cnt, chars_cnt, line_len, longest_len;
    logic             in_word;

    t_stats predicted, observed, wanted;
    logic   predicted_valid;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Hard stop in case the handshake hangs
    initial begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("tb_top: done, errors");
        $finish;
    end

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] x);
        return (&x) ? x : x + 1'b1;
    endfunction

    function automatic t_stats totals(input logic [47:0] l, w, by, c, lg);
        t_stats s;
        s[0] = l;
        s[1] = w;
        s[2] = by;
        s[3] = c;
        s[4] = lg;
        return s;
    endfunction

    task automatic clear_counts();
        lines_cnt   = '0;
        words_cnt   = '0;
        bytes_cnt   = '0;
        chars_cnt   = '0;
        line_len    = '0;
        longest_len = '0;
        in_word     = 1'b0;
    endtask

    // Predictor: update the running counts with one item, emit totals on an end mark
    task automatic count_text_item(input logic [7:0] b, input logic bv, input logic se,
                                   output logic got, output t_stats s);
        logic lead;
        logic blank;
        logic [CNT_W-1:0] top_len;
        lead  = (b & UTF8_TOP_MASK) != UTF8_CONT_CODE;
        blank = (b == ASCII_SP) || (b == ASCII_TAB) || (b == ASCII_LF) ||
                (b == ASCII_CR) || (b == ASCII_VT) || (b == ASCII_FF);
        s = '0;
        if (bv) begin
            bytes_cnt = bump(bytes_cnt);
            if (lead) chars_cnt = bump(chars_cnt);
            if (blank) begin
                in_word = 1'b0;
            end else if (!in_word) begin
                in_word   = 1'b1;
                words_cnt = bump(words_cnt);
            end
            if (b == ASCII_LF) begin
                lines_cnt = bump(lines_cnt);
                if (line_len > longest_len) longest_len = line_len;
                line_len = '0;
            end else if (b != ASCII_CR && lead) begin
                line_len = bump(line_len);
            end
        end
        got = se;
        if (se) begin
            top_len = (line_len > longest_len) ? line_len : longest_len;
            s = totals(48'(lines_cnt), 48'(words_cnt), 48'(bytes_cnt), 48'(chars_cnt),
                       48'(top_len));
            clear_counts();
        end
    endtask

    // Input side: predict every accepted transfer
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) begin
            count_text_item(in_if.data_byte, in_if.byte_valid, in_if.stream_end,
                            predicted_valid, predicted);
            if (predicted_valid)
                pending_totals = {pending_totals, (pin_totals ? pinned_totals : predicted)};
        end
    end

    // Output side: compare every accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            observed = {out_if.longest_line, out_if.char_total, out_if.byte_total,
                        out_if.word_total, out_if.line_total};
            if (pending_totals.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected result, expected none, got lines %0d words %0d",
                         $time, observed[0], observed[1]);
            end else begin
                wanted = pending_totals.pop_front();
                for (int k = 0; k < 5; k++) begin
                    if (observed[k] !== wanted[k]) begin
                        err_cnt++;
                        $display("%0t: %s expected %0d, got %0d", $time, field_name[k],
                                 wanted[k], observed[k]);
                    end
                end
            end
        end
    end

    // Sink ready: random stall bursts, one long hold on request, none at the end
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                out_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge i_clk);
                long_hold_req = 1'b0;
            end else if (!no_idle && $urandom_range(0, 9) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(0, 7)) @(negedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // One transfer on the byte channel, with an optional random gap ahead of it
    task automatic send_item(input logic [7:0] b, input logic bv, input logic se,
                             input logic pin, input t_stats want);
        int gap;
        if (!no_idle && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                in_if.valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        in_if.valid      <= 1'b1;
        in_if.data_byte  <= b;
        in_if.byte_valid <= bv;
        in_if.stream_end <= se;
        pin_totals       <= pin;
        pinned_totals    <= want;
        do @(posedge i_clk); while (!in_if.ready);
        if (bv || se) items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic bv, input logic se);
        send_item(b, bv, se, 1'b0, '0);
    endtask

    // Text-like byte: mostly letters and blanks, sometimes any value
    function automatic logic [7:0] pick_plain_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 8'h61 + 8'($urandom_range(0, 25));
        if (r < 55) return ASCII_SP;
        if (r < 63) return ASCII_LF;
        if (r < 68) return ASCII_CR;
        if (r < 71) return ASCII_TAB;
        if (r < 73) return ASCII_VT;
        if (r < 75) return ASCII_FF;
        return 8'($urandom_range(0, 255));
    endfunction

    // One stream of about len bytes with UTF-8 sequences and idle items mixed in
    task automatic send_text_stream(input int len);
        int n;
        int r;
        int cont;
        logic [31:0] rnd;
        n = 0;
        while (n < len) begin
            r   = $urandom_range(0, 99);
            rnd = $urandom;
            if (r < 5) begin
                send_byte(rnd[7:0], 1'b0, 1'b0);
            end else if (r < 15) begin
                cont = $urandom_range(1, 3);
                case (cont)
                    1: send_byte({3'b110, rnd[4:0]}, 1'b1, 1'b0);
                    2: send_byte({4'b1110, rnd[3:0]}, 1'b1, 1'b0);
                    default: send_byte({5'b11110, rnd[2:0]}, 1'b1, 1'b0);
                endcase
                repeat (cont) begin
                    rnd = $urandom;
                    send_byte({2'b10, rnd[5:0]}, 1'b1, 1'b0);
                end
                n += cont + 1;
            end else begin
                send_byte(pick_plain_byte(), 1'b1, 1'b0);
                n++;
            end
        end
        rnd = $urandom;
        if (rnd[8]) send_byte(rnd[7:0], 1'b0, 1'b1);
        else send_byte(pick_plain_byte(), 1'b1, 1'b1);
    endtask

    task automatic add_row(input logic [7:0] b, input logic bv, input logic se,
                           input logic pin, input t_stats want);
        t_dir_row row;
        row.data = b;
        row.bv   = bv;
        row.se   = se;
        row.pin  = pin;
        row.want = want;
        dir_rows = {dir_rows, row};
    endtask

    // Stimulus
    initial begin
        clear_counts();
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.data_byte  = '0;
        in_if.byte_valid = 1'b0;
        in_if.stream_end = 1'b0;
        pin_totals       = 1'b0;
        pinned_totals    = '0;

        // Empty stream, idle item, bare end with junk data, single-byte streams
        add_row(8'h00, 1'b0, 1'b1, 1'b1, totals(48'd0, 48'd0, 48'd0, 48'd0, 48'd0));
        add_row(8'hFF, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'hFF, 1'b0, 1'b1, 1'b1, totals(48'd0, 48'd0, 48'd0, 48'd0, 48'd0));
        add_row(8'h61, 1'b1, 1'b1, 1'b1, totals(48'd0, 48'd1, 48'd1, 48'd1, 48'd1));
        add_row(ASCII_LF, 1'b1, 1'b1, 1'b1, totals(48'd1, 48'd0, 48'd1, 48'd1, 48'd0));
        add_row(ASCII_CR, 1'b1, 1'b1, 1'b1, totals(48'd0, 48'd0, 48'd1, 48'd1, 48'd0));
        add_row(8'h80, 1'b1, 1'b1, 1'b1, totals(48'd0, 48'd1, 48'd1, 48'd0, 48'd0));
        add_row(8'hFF, 1'b1, 1'b1, 1'b1, totals(48'd0, 48'd1, 48'd1, 48'd1, 48'd1));
        add_row(8'h00, 1'b1, 1'b1, 1'b1, totals(48'd0, 48'd1, 48'd1, 48'd1, 48'd1));
        // All blanks, a word split by an idle item, UTF-8, CR LF, open last line
        add_row(ASCII_TAB, 1'b1, 1'b0, 1'b0, '0);
        add_row(ASCII_VT, 1'b1, 1'b0, 1'b0, '0);
        add_row(ASCII_FF, 1'b1, 1'b0, 1'b0, '0);
        add_row(ASCII_SP, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'h68, 1'b1, 1'b0, 1'b0, '0);
        add_row(ASCII_SP, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h69, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'hC3, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'hA9, 1'b1, 1'b0, 1'b0, '0);
        add_row(ASCII_CR, 1'b1, 1'b0, 1'b0, '0);
        add_row(ASCII_LF, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'hE2, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'h82, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'hAC, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'h7F, 1'b1, 1'b0, 1'b0, '0);
        add_row(ASCII_LF, 1'b0, 1'b1, 1'b0, '0);

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].data, dir_rows[i].bv, dir_rows[i].se, dir_rows[i].pin,
                      dir_rows[i].want);
        end

        // Random streams, mostly short
        rnd_base = items_sent;
        while (items_sent - rnd_base < RANDOM_ITEMS) begin
            if (!hold_done && items_sent - rnd_base >= RANDOM_ITEMS / 2) begin
                // Sink holds off while short streams pile up behind it
                hold_done     = 1'b1;
                long_hold_req = 1'b1;
                repeat (8) send_text_stream($urandom_range(0, 3));
            end
            if (items_sent - rnd_base >= RANDOM_ITEMS * 5 / 6) no_idle = 1'b1;
            if ($urandom_range(0, 9) == 0) send_text_stream($urandom_range(40, 120));
            else send_text_stream($urandom_range(0, 20));
        end

        @(negedge i_clk);
        in_if.valid <= 1'b0;

        while (pending_totals.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
hw/rtl/tssc_pkg.sv
hw/rtl/tssc_if.sv
hw/rtl/text_stream_statistics_counter_core.sv
tb/tb_top.sv
